@@ src/block_average_pixelation_unit_assert.svh @@
`ifndef BLOCK_AVERAGE_PIXELATION_UNIT_ASSERT_SVH
`define BLOCK_AVERAGE_PIXELATION_UNIT_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define BAPU_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BAPU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/bapu_pkg.sv @@
package bapu_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int DEF_MAX_TILE   = 16;

   localparam int PIXEL_W     = 8;
   localparam int SUM_W       = 16;
   localparam int MEAN_W      = 8;
   localparam int STEP_W      = $clog2(MEAN_W);
   localparam int INDEX_W     = 10;
   localparam int SIZE_W      = 5;
   localparam int CNT_W       = 9;
   localparam int TILE_CFG_W  = 5;
   localparam int FRAME_CFG_W = 11;
   localparam int CSR_DATA_W  = 11;
   localparam int CSR_IDX_W   = 2;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [TILE_CFG_W-1:0]  TILE_SIZE_RESET    = 5'd2;
   localparam logic [FRAME_CFG_W-1:0] FRAME_WIDTH_RESET  = 11'd320;
   localparam logic [FRAME_CFG_W-1:0] FRAME_HEIGHT_RESET = 11'd240;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TILE_SIZE    = 2'd0,
      CSR_FRAME_WIDTH  = 2'd1,
      CSR_FRAME_HEIGHT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [SUM_W-1:0]   sum;
      logic [INDEX_W-1:0] column;
      logic [INDEX_W-1:0] row;
      logic [SIZE_W-1:0]  width;
      logic [SIZE_W-1:0]  height;
      logic               done;
   } tile_rec_type;

endpackage

@@ src/bapu_ram.sv @@
module bapu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic                     read_enable,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_address];
      end
   end

   assign read_data = read_data_ff;

endmodule

@@ src/bapu_front.sv @@
`include "block_average_pixelation_unit_assert.svh"

module bapu_front
   import bapu_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int MAX_TILE   = DEF_MAX_TILE
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [PIXEL_W-1:0]    req_pixel,
   output logic                  rec_valid,
   input  logic                  rec_ready,
   output tile_rec_type          rec_data
);

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int OW = $clog2(MAX_TILE + 1);

   logic [TILE_CFG_W-1:0]  tile_size_ff;
   logic [FRAME_CFG_W-1:0] frame_width_ff;
   logic [FRAME_CFG_W-1:0] frame_height_ff;
   logic                   restart;

   logic [XW-1:0] px_ff, px_in, tilex_ff, tilex_in;
   logic [YW-1:0] py_ff, py_in, tiley_ff, tiley_in;
   logic [OW-1:0] offx_ff, offx_in, offy_ff, offy_in;

   logic [OW-1:0] ts, tw, th;
   logic [WW-1:0] w, rem_w;
   logic [HW-1:0] h, rem_h;
   logic [XW-1:0] bx;
   logic [YW-1:0] by;
   logic          first, complete, last_x, last_y, accept;

   logic               s1_valid_ff, s1_valid_in;
   logic [PIXEL_W-1:0] s1_pixel_ff;
   logic [XW-1:0]      s1_tx_ff;
   logic               s1_first_ff, s1_fwd_ff, s1_complete_ff;
   tile_rec_type       s1_rec_ff;
   logic [SUM_W-1:0]   fwd_sum_ff;
   logic [SUM_W-1:0]   ram_rdata, base, sum;
   logic               s1_go, ram_we;

   // register file, any valid index restarts the frame
   always_comb begin
      unique case (csr_index)
         CSR_TILE_SIZE, CSR_FRAME_WIDTH, CSR_FRAME_HEIGHT: restart = csr_write_enable;
         default: restart = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_size_ff    <= TILE_SIZE_RESET;
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TILE_SIZE:    tile_size_ff    <= csr_write_data[TILE_CFG_W-1:0];
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_write_data[FRAME_CFG_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_write_data[FRAME_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // clamped geometry and tile classification
   always_comb begin
      if (tile_size_ff == '0) ts = OW'(1);
      else if (32'(tile_size_ff) > MAX_TILE) ts = OW'(MAX_TILE);
      else ts = OW'(tile_size_ff);

      if (frame_width_ff == '0) w = WW'(1);
      else if (32'(frame_width_ff) > MAX_WIDTH) w = WW'(MAX_WIDTH);
      else w = WW'(frame_width_ff);

      if (frame_height_ff == '0) h = HW'(1);
      else if (32'(frame_height_ff) > MAX_HEIGHT) h = HW'(MAX_HEIGHT);
      else h = HW'(frame_height_ff);

      first = (offx_ff == '0) && (offy_ff == '0);
      bx    = px_ff - XW'(offx_ff);
      by    = py_ff - YW'(offy_ff);
      rem_w = w - WW'(bx);
      rem_h = h - HW'(by);
      tw    = (rem_w < WW'(ts)) ? OW'(rem_w) : ts;
      th    = (rem_h < HW'(ts)) ? OW'(rem_h) : ts;
      complete = ({1'b0, offx_ff} + 1'b1 == {1'b0, tw}) &&
                 ({1'b0, offy_ff} + 1'b1 == {1'b0, th});
      last_x = (WW'(px_ff) + WW'(1)) >= w;
      last_y = (HW'(py_ff) + HW'(1)) >= h;
   end

   // next raster position
   always_comb begin
      px_in    = px_ff;
      py_in    = py_ff;
      offx_in  = offx_ff;
      offy_in  = offy_ff;
      tilex_in = tilex_ff;
      tiley_in = tiley_ff;
      if (restart) begin
         px_in    = '0;
         py_in    = '0;
         offx_in  = '0;
         offy_in  = '0;
         tilex_in = '0;
         tiley_in = '0;
      end else if (accept) begin
         if (last_x) begin
            px_in    = '0;
            offx_in  = '0;
            tilex_in = '0;
            if (last_y) begin
               py_in    = '0;
               offy_in  = '0;
               tiley_in = '0;
            end else begin
               py_in = py_ff + 1'b1;
               if ({1'b0, offy_ff} + 1'b1 >= {1'b0, ts}) begin
                  offy_in  = '0;
                  tiley_in = tiley_ff + 1'b1;
               end else begin
                  offy_in = offy_ff + 1'b1;
               end
            end
         end else begin
            px_in = px_ff + 1'b1;
            if ({1'b0, offx_ff} + 1'b1 >= {1'b0, ts}) begin
               offx_in  = '0;
               tilex_in = tilex_ff + 1'b1;
            end else begin
               offx_in = offx_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         px_ff    <= '0;
         py_ff    <= '0;
         offx_ff  <= '0;
         offy_ff  <= '0;
         tilex_ff <= '0;
         tiley_ff <= '0;
      end else begin
         px_ff    <= px_in;
         py_ff    <= py_in;
         offx_ff  <= offx_in;
         offy_ff  <= offy_in;
         tilex_ff <= tilex_in;
         tiley_ff <= tiley_in;
      end
   end

   // accumulate stage, the sum of the previous word is forwarded on a same-edge read
   assign s1_go     = !s1_complete_ff || rec_ready;
   assign ram_we    = s1_valid_ff && s1_go;
   assign req_ready = (!s1_valid_ff || s1_go) && !csr_write_enable;
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (s1_first_ff) base = '0;
      else if (s1_fwd_ff) base = fwd_sum_ff;
      else base = ram_rdata;
      sum = base + SUM_W'(s1_pixel_ff);

      if (accept) s1_valid_in = 1'b1;
      else if (s1_go) s1_valid_in = 1'b0;
      else s1_valid_in = s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_we) begin
         fwd_sum_ff <= sum;
      end
      if (accept) begin
         s1_pixel_ff      <= req_pixel;
         s1_tx_ff         <= tilex_ff;
         s1_first_ff      <= first;
         s1_fwd_ff        <= ram_we && (s1_tx_ff == tilex_ff);
         s1_complete_ff   <= complete;
         s1_rec_ff.sum    <= '0;
         s1_rec_ff.column <= INDEX_W'(tilex_ff);
         s1_rec_ff.row    <= INDEX_W'(tiley_ff);
         s1_rec_ff.width  <= SIZE_W'(tw);
         s1_rec_ff.height <= SIZE_W'(th);
         s1_rec_ff.done   <= last_x && last_y;
      end
   end

   bapu_ram #(
      .WIDTH (SUM_W),
      .DEPTH (MAX_WIDTH)
   ) u_column_sums (
      .clock         (clock),
      .write_enable  (ram_we),
      .write_address (s1_tx_ff),
      .write_data    (sum),
      .read_enable   (accept),
      .read_address  (tilex_ff),
      .read_data     (ram_rdata)
   );

   always_comb begin
      rec_data     = s1_rec_ff;
      rec_data.sum = sum;
   end

   assign rec_valid = s1_valid_ff && s1_complete_ff;

   `BAPU_ASSERT_NOW(a_pixel_in_frame, accept, (WW'(px_ff) < w) && (HW'(py_ff) < h), "position outside frame")

endmodule

@@ src/bapu_queue.sv @@
`include "block_average_pixelation_unit_assert.svh"

module bapu_queue
   import bapu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  tile_rec_type push_data,
   output logic         pop_valid,
   input  logic         pop_ready,
   output tile_rec_type pop_data
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   tile_rec_type  entries_ff [QUEUE_DEPTH];
   logic [PW-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          push, pop;

   assign push_ready = count_ff != CW'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entries_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (32'(wptr_ff) == QUEUE_DEPTH - 1) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (32'(rptr_ff) == QUEUE_DEPTH - 1) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wptr_ff] <= push_data;
      end
   end

   `BAPU_ASSERT_NEXT(a_count_tracks, push && !pop, count_ff == $past(count_ff) + 1'b1, "queue count lost a word")
   `BAPU_ASSERT_NOW(a_ptr_gap, count_ff == '0, wptr_ff == rptr_ff, "queue pointers disagree when empty")

endmodule

@@ src/bapu_back.sv @@
`include "block_average_pixelation_unit_assert.svh"

module bapu_back
   import bapu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               rec_valid,
   output logic               rec_ready,
   input  tile_rec_type       rec_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [MEAN_W-1:0]  rsp_tile_mean,
   output logic [INDEX_W-1:0] rsp_tile_column,
   output logic [INDEX_W-1:0] rsp_tile_row,
   output logic [SIZE_W-1:0]  rsp_tile_width,
   output logic [SIZE_W-1:0]  rsp_tile_height,
   output logic               rsp_frame_done
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_HOLD = 3'b100
   } back_state_type;

   back_state_type     state_ff, state_in;
   tile_rec_type       rec_ff;
   logic [SUM_W-1:0]   rem_ff, rem_in;
   logic [MEAN_W-1:0]  quo_ff, quo_in, mean;
   logic [CNT_W-1:0]   cnt_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [SUM_W:0]     shifted;
   logic               fits, out_free, load, load_out;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [MEAN_W-1:0]  rsp_mean_ff;
   tile_rec_type       rsp_rec_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rec_ready = state_ff == ST_IDLE;
   assign load      = rec_valid && rec_ready;

   // one quotient bit a cycle, msb first
   always_comb begin
      shifted = (SUM_W + 1)'(cnt_ff) << step_ff;
      fits    = {1'b0, rem_ff} >= shifted;
      rem_in  = fits ? rem_ff - shifted[SUM_W-1:0] : rem_ff;
      quo_in  = {quo_ff[MEAN_W-2:0], fits};
      mean    = (state_ff == ST_DIV) ? quo_in : quo_ff;
   end

   always_comb begin
      state_in     = state_ff;
      load_out     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (rec_valid) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (step_ff == '0) begin
               if (out_free) begin
                  load_out = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (load_out) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rec_ff  <= rec_data;
         rem_ff  <= rec_data.sum;
         quo_ff  <= '0;
         cnt_ff  <= CNT_W'(rec_data.width) * CNT_W'(rec_data.height);
         step_ff <= STEP_W'(MEAN_W - 1);
      end else if (state_ff == ST_DIV) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         step_ff <= step_ff - 1'b1;
      end
      if (load_out) begin
         rsp_mean_ff <= mean;
         rsp_rec_ff  <= rec_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tile_mean   = rsp_mean_ff;
   assign rsp_tile_column = rsp_rec_ff.column;
   assign rsp_tile_row    = rsp_rec_ff.row;
   assign rsp_tile_width  = rsp_rec_ff.width;
   assign rsp_tile_height = rsp_rec_ff.height;
   assign rsp_frame_done  = rsp_rec_ff.done;

   `BAPU_ASSERT_NOW(a_divisor_nonzero, state_ff == ST_DIV, cnt_ff != '0, "zero pixel count in divider")

endmodule

@@ src/block_average_pixelation_unit.sv @@
// block average pixelation
// req_ channel: one 8-bit grayscale pixel per word, raster order, valid/ready.
// rsp_ channel: one word per finished tile with its truncated mean, tile column
// and row, clipped width and height, and a flag on the last tile of the frame.
// csr_ port: single-cycle writes of tile size (0), frame width (1) and frame
// height (2); a write to any of these restarts the frame at pixel zero.
// pixels are taken one per cycle while the queue has room and no csr_ write
// is under way: the column sum memory is read at acceptance and written back
// as the word leaves the accumulate stage, bypassed for back-to-back words.
// the eight-step shift-subtract divider registers each finished tile's mean
// onto rsp_, fed through the two-word queue; tiles finishing faster than it
// takes them fill the queue and then hold off req_ready until it catches up.
// a stalled rsp_ word holds while the divider works on the next tile.
// reset restores 2 x 2 tiles on a 320 x 240 frame and empties the pipeline;
// the column sum memory needs no clearing, since each tile's first pixel
// overwrites its sum.
module block_average_pixelation_unit
   import bapu_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int MAX_TILE   = DEF_MAX_TILE
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [PIXEL_W-1:0]    req_pixel,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [MEAN_W-1:0]     rsp_tile_mean,
   output logic [INDEX_W-1:0]    rsp_tile_column,
   output logic [INDEX_W-1:0]    rsp_tile_row,
   output logic [SIZE_W-1:0]     rsp_tile_width,
   output logic [SIZE_W-1:0]     rsp_tile_height,
   output logic                  rsp_frame_done
);

   logic         front_valid, front_ready, back_valid, back_ready;
   tile_rec_type front_data, back_data;

   bapu_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_TILE   (MAX_TILE)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel        (req_pixel),
      .rec_valid        (front_valid),
      .rec_ready        (front_ready),
      .rec_data         (front_data)
   );

   bapu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_data),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_data)
   );

   bapu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .rec_valid       (back_valid),
      .rec_ready       (back_ready),
      .rec_data        (back_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_tile_mean   (rsp_tile_mean),
      .rsp_tile_column (rsp_tile_column),
      .rsp_tile_row    (rsp_tile_row),
      .rsp_tile_width  (rsp_tile_width),
      .rsp_tile_height (rsp_tile_height),
      .rsp_frame_done  (rsp_frame_done)
   );

endmodule
